/* hw/rtl/sdm_pkg.sv */
// Shared types, codes and segment tables for the status display mode controller.
// No dependencies; used by every module of the block.
package sdm_pkg;

  localparam int unsigned FAULT_COUNT = 32;   // faults 1..FAULT_COUNT take part in the scan
  localparam int unsigned FAULT_BITS  = 32;

  // display modes
  localparam logic [1:0] MODE_BATT  = 2'd0;
  localparam logic [1:0] MODE_FAULT = 2'd1;
  localparam logic [1:0] MODE_HOST  = 2'd2;

  // word kinds
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CMD  = 1'b1;

  localparam logic [7:0] SEG_BLANK  = 8'hFF;
  localparam logic [6:0] LEVEL_FULL = 7'd100;
  localparam logic [3:0] BAR_FULL   = 4'd8;
  localparam logic [3:0] HEX_E      = 4'hE;

  typedef struct packed {
    logic        op;
    logic [7:0]  battery_level;
    logic        charging;
    logic        system_running;
    logic [31:0] fault_flags;
    logic        cmd_mode;
    logic [7:0]  cmd_hundred;
    logic [7:0]  cmd_ten;
    logic [7:0]  cmd_single;
  } sdm_item_t;

  typedef struct packed {
    logic [3:0][7:0] frame;     // [0] leftmost digit, [3] bar
    logic            percent;
    logic [1:0]      mode;
    logic [1:0]      saved;
    logic [5:0]      cursor;
    logic [3:0]      bar_step;
    logic [2:0][7:0] host;      // [0] hundreds
  } sdm_state_t;

  typedef struct packed {
    logic [3:0][7:0] frame;
    logic            percent;
    logic [1:0]      shown;
  } sdm_result_t;

  // fault scan status
  typedef struct packed {
    logic       any;    // some fault in 1..FAULT_COUNT active
    logic       hit;    // some fault at or after the cursor
    logic [5:0] num;    // first such fault number
    logic       more;   // another one after it
  } sdm_scan_t;

  localparam sdm_state_t STATE_RESET = '{
    frame:    {8'h00, 8'h80, 8'h80, 8'h80},
    percent:  1'b1,
    mode:     MODE_BATT,
    saved:    MODE_BATT,
    cursor:   6'd1,
    bar_step: 4'd0,
    host:     '0
  };

  function automatic logic [7:0] seg_hex(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'h0: s = 8'hC0;  4'h1: s = 8'hF9;  4'h2: s = 8'hA4;  4'h3: s = 8'hB0;
      4'h4: s = 8'h99;  4'h5: s = 8'h92;  4'h6: s = 8'h82;  4'h7: s = 8'hF8;
      4'h8: s = 8'h80;  4'h9: s = 8'h90;  4'hA: s = 8'h88;  4'hB: s = 8'h83;
      4'hC: s = 8'hC6;  4'hD: s = 8'hA1;  4'hE: s = 8'h86;  default: s = 8'h84;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] seg_bar(input logic [3:0] n);
    logic [7:0] s;
    case (n)
      4'd0: s = 8'hFF;  4'd1: s = 8'h7F;  4'd2: s = 8'h3F;  4'd3: s = 8'h1F;
      4'd4: s = 8'h0F;  4'd5: s = 8'h07;  4'd6: s = 8'h03;  4'd7: s = 8'h01;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // v / 10 for v <= 100 by reciprocal multiply (205 / 2048)
  function automatic logic [3:0] div10(input logic [6:0] v);
    logic [14:0] p;
    p = {8'b0, v} * 15'd205;
    return p[14:11];
  endfunction

endpackage

/* hw/rtl/sdm_fault_scan.sv */
// Find-first encoder over the fault bitmap, starting at the fault cursor.
// Depends on sdm_pkg.
module sdm_fault_scan #(
  parameter int unsigned FAULT_COUNT = sdm_pkg::FAULT_COUNT
) (
  input  logic [31:0]       flags_i,
  input  logic [5:0]        cursor_i,
  output sdm_pkg::sdm_scan_t scan_o
);

  logic [31:0] valid_mask;
  logic [31:0] from_mask;
  logic [31:0] masked;
  logic [5:0]  num;

  always_comb begin
    for (int j = 0; j < int'(sdm_pkg::FAULT_BITS); j++) begin
      valid_mask[j] = (j < int'(FAULT_COUNT));
      from_mask[j]  = (6'(j + 1) >= cursor_i);
    end
  end

  assign masked = flags_i & valid_mask & from_mask;

  // lowest set bit wins
  always_comb begin
    num = '0;
    for (int j = int'(sdm_pkg::FAULT_BITS) - 1; j >= 0; j--) begin
      if (masked[j]) num = 6'(j + 1);
    end
  end

  assign scan_o.any  = |(flags_i & valid_mask);
  assign scan_o.hit  = |masked;
  assign scan_o.num  = num;
  assign scan_o.more = |(masked & (masked - 32'd1));

endmodule

/* hw/rtl/sdm_frame.sv */
// Next-state and frame logic for one word: battery frame, fault codes, host digits.
// Depends on sdm_pkg and sdm_fault_scan.
module sdm_frame #(
  parameter int unsigned FAULT_COUNT = sdm_pkg::FAULT_COUNT
) (
  input  sdm_pkg::sdm_item_t   item_i,
  input  sdm_pkg::sdm_state_t  state_i,
  output sdm_pkg::sdm_state_t  state_o,
  output sdm_pkg::sdm_result_t result_o
);

  sdm_pkg::sdm_scan_t scan;

  logic [6:0] level;
  logic [3:0] bars;
  logic [3:0] lvl_tens;
  logic [6:0] lvl_units;
  logic [4:0] bar_sum;
  logic [3:0] bar_idx;
  logic [3:0] step_nxt;
  logic [3:0] flt_tens;
  logic [6:0] flt_units;
  logic [3:0][7:0] batt;

  sdm_fault_scan #(
    .FAULT_COUNT (FAULT_COUNT)
  ) u_scan (
    .flags_i  (item_i.fault_flags),
    .cursor_i (state_i.cursor),
    .scan_o   (scan)
  );

  assign level = (item_i.battery_level > {1'b0, sdm_pkg::LEVEL_FULL}) ?
                 sdm_pkg::LEVEL_FULL : item_i.battery_level[6:0];

  always_comb begin
    if (level == 7'd0)       bars = 4'd0;
    else if (level <= 7'd12) bars = 4'd1;
    else if (level <= 7'd25) bars = 4'd2;
    else if (level <= 7'd37) bars = 4'd3;
    else if (level <= 7'd50) bars = 4'd4;
    else if (level <= 7'd62) bars = 4'd5;
    else if (level <= 7'd75) bars = 4'd6;
    else if (level <= 7'd87) bars = 4'd7;
    else                     bars = 4'd8;
  end

  assign lvl_tens  = sdm_pkg::div10(level);
  assign lvl_units = level - ({3'b0, lvl_tens} * 7'd10);

  // charging animation; index saturates at a full bar
  assign bar_sum = {1'b0, bars} + {1'b0, state_i.bar_step};
  always_comb begin
    if (item_i.charging) begin
      if (bar_sum >= 5'd8) begin
        bar_idx  = sdm_pkg::BAR_FULL;
        step_nxt = 4'd0;
      end else begin
        bar_idx  = bar_sum[3:0];
        step_nxt = state_i.bar_step + 4'd1;
      end
    end else begin
      bar_idx  = bars;
      step_nxt = 4'd0;
    end
  end

  assign batt[0] = (level == sdm_pkg::LEVEL_FULL) ? sdm_pkg::seg_hex(4'd1) : sdm_pkg::SEG_BLANK;
  assign batt[1] = sdm_pkg::seg_hex((lvl_tens == 4'd10) ? 4'd0 : lvl_tens);
  assign batt[2] = sdm_pkg::seg_hex(lvl_units[3:0]);
  assign batt[3] = sdm_pkg::seg_bar(bar_idx);

  assign flt_tens  = sdm_pkg::div10({1'b0, scan.num});
  assign flt_units = {1'b0, scan.num} - ({3'b0, flt_tens} * 7'd10);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (item_i.op == sdm_pkg::OP_CMD) begin
      state_o.host = {item_i.cmd_single, item_i.cmd_ten, item_i.cmd_hundred};
      if (item_i.cmd_mode) begin
        if (state_i.mode != sdm_pkg::MODE_HOST) begin
          state_o.saved = state_i.mode;
          state_o.mode  = sdm_pkg::MODE_HOST;
        end
      end else if (state_i.mode == sdm_pkg::MODE_HOST) begin
        state_o.mode = state_i.saved;
      end
    end else begin
      state_o.bar_step = step_nxt;
      state_o.frame[3] = batt[3];
      unique case (state_i.mode)
        sdm_pkg::MODE_BATT: begin
          state_o.frame   = batt;
          state_o.percent = 1'b1;
          if (item_i.system_running) begin
            state_o.cursor = 6'd1;
            state_o.mode   = scan.any ? sdm_pkg::MODE_FAULT : sdm_pkg::MODE_BATT;
          end
        end
        sdm_pkg::MODE_FAULT: begin
          if (!scan.hit) begin
            state_o.cursor = 6'd1;
            state_o.mode   = sdm_pkg::MODE_BATT;
          end else begin
            state_o.frame[0] = sdm_pkg::seg_hex(sdm_pkg::HEX_E);
            state_o.frame[1] = sdm_pkg::seg_hex(flt_tens);
            state_o.frame[2] = sdm_pkg::seg_hex(flt_units[3:0]);
            state_o.percent  = 1'b0;
            if (scan.more) begin
              state_o.cursor = scan.num + 6'd1;
            end else begin
              state_o.cursor = 6'd1;
              state_o.mode   = sdm_pkg::MODE_BATT;
            end
          end
        end
        sdm_pkg::MODE_HOST: begin
          state_o.percent = 1'b0;
          for (int k = 0; k < 3; k++) begin
            if (state_i.host[k] == sdm_pkg::SEG_BLANK) begin
              state_o.frame[k] = sdm_pkg::SEG_BLANK;
            end else if (state_i.host[k] <= 8'd15) begin
              state_o.frame[k] = sdm_pkg::seg_hex(state_i.host[k][3:0]);
            end
          end
        end
        default: ;
      endcase
      result_o.frame   = state_o.frame;
      result_o.percent = state_o.percent;
      result_o.shown   = state_i.mode;
    end
  end

endmodule

/* hw/rtl/status_display_mode_controller_core.sv */
// Top level of the status display mode controller: input register, display state,
// result register. Depends on sdm_pkg and sdm_frame.
//
// Each word on the slave stream is either an update tick (tuser = 0) or a host
// display command (tuser = 1). A tick produces exactly one frame word on the master
// stream: three active-low digit bytes, the battery bar byte, the percent flag, and in
// tuser the mode that was in force when the tick began. A command produces no word;
// it only latches the host digits and enters or leaves host mode. A word accepted
// into the input register sits there while the frame logic works on it, and a tick's
// result is loaded into the result register as the word leaves the input register.
// Throughput is one word per cycle; the
// only limit is the result register, so ticks stall only while a result waits on
// m_axis_tready, while commands pass through even then. The display state updates
// in word order as each word leaves the input register. No clearing pass is needed
// after reset.
module status_display_mode_controller_core #(
  parameter int unsigned FAULT_COUNT = sdm_pkg::FAULT_COUNT  // faults 1..FAULT_COUNT scanned
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] battery_level, [8] charging, [9] system_running, [41:10] fault_flags,
  // [42] cmd_mode, [50:43] cmd_hundred, [58:51] cmd_ten, [66:59] cmd_single, rest 0
  input  logic [71:0] s_axis_tdata,
  // [0] op
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] seg_digit0, [15:8] seg_digit1, [23:16] seg_digit2, [31:24] seg_bar,
  // [32] percent_sign_on, rest 0
  output logic [39:0] m_axis_tdata,
  // [1:0] shown_mode
  output logic [1:0]  m_axis_tuser
);

  sdm_pkg::sdm_item_t   item_q;
  logic                 in_vld_q;
  sdm_pkg::sdm_state_t  state_q, state_d;
  sdm_pkg::sdm_result_t res_d, res_q;
  logic                 out_vld_q;
  logic                 advance;
  logic                 in_take;

  // a command never needs the result slot; a tick needs it free or draining
  assign advance = in_vld_q &&
                   ((item_q.op == sdm_pkg::OP_CMD) || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // input register: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  // input register: payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.op             <= s_axis_tuser[0];
      item_q.battery_level  <= s_axis_tdata[7:0];
      item_q.charging       <= s_axis_tdata[8];
      item_q.system_running <= s_axis_tdata[9];
      item_q.fault_flags    <= s_axis_tdata[41:10];
      item_q.cmd_mode       <= s_axis_tdata[42];
      item_q.cmd_hundred    <= s_axis_tdata[50:43];
      item_q.cmd_ten        <= s_axis_tdata[58:51];
      item_q.cmd_single     <= s_axis_tdata[66:59];
    end
  end

  sdm_frame #(
    .FAULT_COUNT (FAULT_COUNT)
  ) u_frame (
    .item_i   (item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // display state moves once per word leaving the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdm_pkg::STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && (item_q.op == sdm_pkg::OP_TICK)) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && (item_q.op == sdm_pkg::OP_TICK)) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, res_q.percent, res_q.frame[3], res_q.frame[2],
                          res_q.frame[1], res_q.frame[0]};
  assign m_axis_tuser  = res_q.shown;

endmodule

/* hw/rtl/sdm_checker.sv */
// Port-level checks on the status display mode controller, bound to its top level.
// Depends on sdm_pkg and status_display_mode_controller_core.
module sdm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [71:0] s_axis_tdata,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // host frames never light the percent sign
  a_host_no_pct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == sdm_pkg::MODE_HOST) |-> !m_axis_tdata[32])
    else $error("percent sign lit in host mode");

  // battery frames: percent lit, hundreds digit blank or '1'
  a_batt_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == sdm_pkg::MODE_BATT) |->
      m_axis_tdata[32] &&
      ((m_axis_tdata[7:0] == sdm_pkg::SEG_BLANK) ||
       (m_axis_tdata[7:0] == sdm_pkg::seg_hex(4'd1))))
    else $error("malformed battery frame");

  // the shown mode is always a real one
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("unknown display mode shown");

endmodule

bind status_display_mode_controller_core sdm_checker u_sdm_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for status_display_mode_controller_core: directed and random
// ticks and host commands on the slave stream, frames checked against a predictor.
// Depends on sdm_pkg and the block's RTL only.
module tb;

  localparam int unsigned QUIET_LIMIT = 1000;  // cycles with no word moving on either side
  localparam int unsigned RANDOM_WORDS = 450;

  // one expected frame word
  typedef struct packed {
    logic [7:0] digit0;
    logic [7:0] digit1;
    logic [7:0] digit2;
    logic [7:0] bar;
    logic       percent;
    logic [1:0] shown;
  } frame_t;

  // Tracks the display state, predicts the frame of every tick, checks the frames out.
  class display_frame_checker;
    logic [7:0] screen [4];
    logic       pct_lit;
    logic [1:0] mode_now;
    logic [1:0] mode_saved;
    logic [5:0] cursor;
    logic [3:0] bar_phase;
    logic [7:0] host_raw [3];
    frame_t     frames_due [$];
    int unsigned errors;

    function new();
      screen = '{8'h80, 8'h80, 8'h80, 8'h00};
      pct_lit = 1'b1;
      mode_now = sdm_pkg::MODE_BATT;
      mode_saved = sdm_pkg::MODE_BATT;
      cursor = 6'd1;
      bar_phase = 4'd0;
      host_raw = '{8'h00, 8'h00, 8'h00};
      errors = 0;
    endfunction

    static function logic [7:0] digit_pattern(int unsigned d);
      case (d)
        0: return 8'hC0;   1: return 8'hF9;   2: return 8'hA4;   3: return 8'hB0;
        4: return 8'h99;   5: return 8'h92;   6: return 8'h82;   7: return 8'hF8;
        8: return 8'h80;   9: return 8'h90;  10: return 8'h88;  11: return 8'h83;
        12: return 8'hC6; 13: return 8'hA1;  14: return 8'h86;  default: return 8'h84;
      endcase
    endfunction

    static function logic [7:0] bar_pattern(int unsigned n);
      case (n)
        0: return 8'hFF;  1: return 8'h7F;  2: return 8'h3F;  3: return 8'h1F;
        4: return 8'h0F;  5: return 8'h07;  6: return 8'h03;  7: return 8'h01;
        default: return 8'h00;
      endcase
    endfunction

    // lowest active fault number in [from, FAULT_COUNT], 0 when none
    static function int unsigned first_active(logic [31:0] flags, int unsigned from);
      for (int unsigned i = from; i <= sdm_pkg::FAULT_COUNT && i <= 32; i++)
        if (flags[i-1]) return i;
      return 0;
    endfunction

    // host byte: hex digit, blank, or anything else leaves the digit alone
    function void host_digit(int unsigned pos, logic [7:0] v);
      if (v == sdm_pkg::SEG_BLANK) screen[pos] = sdm_pkg::SEG_BLANK;
      else if (v <= 8'd15) screen[pos] = digit_pattern(v);
    endfunction

    // note an accepted word; a tick queues its frame
    function void absorb_word(sdm_pkg::sdm_item_t w);
      int unsigned level, bars, idx, f, code;
      logic [7:0]  batt [4];
      logic [1:0]  shown;
      frame_t      fr;
      if (w.op == sdm_pkg::OP_CMD) begin
        host_raw = '{w.cmd_hundred, w.cmd_ten, w.cmd_single};
        if (w.cmd_mode) begin
          if (mode_now != sdm_pkg::MODE_HOST) begin
            mode_saved = mode_now;
            mode_now = sdm_pkg::MODE_HOST;
          end
        end else if (mode_now == sdm_pkg::MODE_HOST) begin
          mode_now = mode_saved;
        end
        return;
      end
      level = (w.battery_level > 8'd100) ? 100 : w.battery_level;
      if (level == 0) bars = 0;
      else if (level <= 12) bars = 1;
      else if (level <= 25) bars = 2;
      else if (level <= 37) bars = 3;
      else if (level <= 50) bars = 4;
      else if (level <= 62) bars = 5;
      else if (level <= 75) bars = 6;
      else if (level <= 87) bars = 7;
      else bars = 8;
      batt[0] = (level / 100 == 0) ? sdm_pkg::SEG_BLANK : digit_pattern(1);
      batt[1] = digit_pattern((level / 10) % 10);
      batt[2] = digit_pattern(level % 10);
      // charging: bar climbs one step per tick, saturating at full then restarting
      if (w.charging) begin
        idx = bars + bar_phase;
        bar_phase = bar_phase + 4'd1;
        if (idx >= 8) begin
          bar_phase = 4'd0;
          idx = 8;
        end
      end else begin
        bar_phase = 4'd0;
        idx = bars;
      end
      batt[3] = bar_pattern(idx);
      screen[3] = batt[3];
      shown = mode_now;
      case (mode_now)
        sdm_pkg::MODE_BATT: begin
          screen = batt;
          pct_lit = 1'b1;
          if (w.system_running) begin
            cursor = 6'd1;
            mode_now = (first_active(w.fault_flags, 1) != 0) ?
                       sdm_pkg::MODE_FAULT : sdm_pkg::MODE_BATT;
          end
        end
        sdm_pkg::MODE_FAULT: begin
          f = first_active(w.fault_flags, cursor);
          if (f == 0) begin
            // nothing left to show: frame digits stay as they were
            cursor = 6'd1;
            mode_now = sdm_pkg::MODE_BATT;
          end else begin
            code = (f > 99) ? 99 : f;
            screen[0] = digit_pattern(14);
            screen[1] = digit_pattern((code / 10) % 10);
            screen[2] = digit_pattern(code % 10);
            pct_lit = 1'b0;
            cursor = 6'(f + 1);
            if (first_active(w.fault_flags, f + 1) == 0) begin
              cursor = 6'd1;
              mode_now = sdm_pkg::MODE_BATT;
            end
          end
        end
        sdm_pkg::MODE_HOST: begin
          pct_lit = 1'b0;
          for (int unsigned p = 0; p < 3; p++) host_digit(p, host_raw[p]);
        end
        default: ;
      endcase
      fr.digit0 = screen[0];
      fr.digit1 = screen[1];
      fr.digit2 = screen[2];
      fr.bar = screen[3];
      fr.percent = pct_lit;
      fr.shown = shown;
      frames_due.push_back(fr);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // compare an accepted frame word with the oldest prediction
    function void compare_frame(logic [39:0] data, logic [1:0] user);
      frame_t want;
      if (frames_due.size() == 0) begin
        $error("frame word %h / %h with no tick waiting", data, user);
        errors++;
        return;
      end
      want = frames_due.pop_front();
      check_field("seg_digit0", want.digit0, data[7:0]);
      check_field("seg_digit1", want.digit1, data[15:8]);
      check_field("seg_digit2", want.digit2, data[23:16]);
      check_field("seg_bar", want.bar, data[31:24]);
      check_field("percent_sign_on", {7'd0, want.percent}, {7'd0, data[32]});
      check_field("shown_mode", {6'd0, want.shown}, {6'd0, user});
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  display_frame_checker chk;
  bit          no_gaps = 1'b0;   // both sides run flat out while set
  int unsigned quiet_cycles = 0;

  // battery levels on either side of each bar threshold
  int unsigned level_marks [17] = '{0, 12, 13, 25, 26, 37, 38, 50, 51, 62, 63, 75, 76,
                                    87, 88, 99, 100};

  status_display_mode_controller_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // result side back-pressure
  always @(negedge clk_i) m_axis_tready <= no_gaps || ($urandom_range(99) >= 13);

  // frame checking and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) chk.compare_frame(m_axis_tdata, m_axis_tuser);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  function automatic sdm_pkg::sdm_item_t make_tick(logic [7:0] level, logic chg, logic run,
                                                   logic [31:0] faults);
    sdm_pkg::sdm_item_t w;
    w.op = sdm_pkg::OP_TICK;
    w.battery_level = level;
    w.charging = chg;
    w.system_running = run;
    w.fault_flags = faults;
    // command fields are don't-care on a tick; keep them moving
    w.cmd_mode = 1'($urandom_range(1));
    w.cmd_hundred = 8'($urandom_range(255));
    w.cmd_ten = 8'($urandom_range(255));
    w.cmd_single = 8'($urandom_range(255));
    return w;
  endfunction

  function automatic sdm_pkg::sdm_item_t make_cmd(logic enter, logic [7:0] h, logic [7:0] t,
                                                  logic [7:0] s);
    sdm_pkg::sdm_item_t w;
    w.op = sdm_pkg::OP_CMD;
    w.battery_level = 8'($urandom_range(255));
    w.charging = 1'($urandom_range(1));
    w.system_running = 1'($urandom_range(1));
    w.fault_flags = $urandom();
    w.cmd_mode = enter;
    w.cmd_hundred = h;
    w.cmd_ten = t;
    w.cmd_single = s;
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with tvalid
  // still high, so a following word goes out back to back.
  task automatic send_word(input sdm_pkg::sdm_item_t w);
    while (!no_gaps && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= w.op;
    s_axis_tdata <= {5'd0, w.cmd_single, w.cmd_ten, w.cmd_hundred, w.cmd_mode,
                     w.fault_flags, w.system_running, w.charging, w.battery_level};
    do @(posedge clk_i); while (!s_axis_tready);
    chk.absorb_word(w);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] host_byte();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 5) return 8'($urandom_range(15));
    if (r < 7) return sdm_pkg::SEG_BLANK;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [31:0] fresh_faults();
    logic [31:0] f;
    int unsigned r;
    f = '0;
    r = $urandom_range(9);
    if (r < 4) return '0;
    if (r < 8) begin
      repeat ($urandom_range(3, 1)) f[$urandom_range(31)] = 1'b1;
      return f;
    end
    if (r == 8) return $urandom();
    return 32'h8000_0000 >> $urandom_range(3);
  endfunction

  initial begin
    logic [31:0] fault_now;
    logic [7:0]  lvl;
    int unsigned r;
    chk = new();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: bar thresholds, clamp, charging animation and saturation
    send_word(make_tick(8'd0, 1'b0, 1'b0, 32'h0));
    send_word(make_tick(8'd12, 1'b1, 1'b0, 32'h0));
    send_word(make_tick(8'd13, 1'b1, 1'b0, 32'h0));
    send_word(make_tick(8'd100, 1'b1, 1'b0, 32'h0));
    send_word(make_tick(8'd255, 1'b0, 1'b0, 32'h0));
    // faults ignored while not running
    send_word(make_tick(8'd101, 1'b1, 1'b0, 32'hFFFF_FFFF));
    // first and last fault numbers; scan carries on with running low
    send_word(make_tick(8'd50, 1'b0, 1'b1, 32'h8000_0001));
    send_word(make_tick(8'd50, 1'b0, 1'b0, 32'h8000_0001));
    send_word(make_tick(8'd50, 1'b0, 1'b0, 32'h8000_0001));
    // fault mode entered, then every fault clears: digits held, back to battery
    send_word(make_tick(8'd77, 1'b0, 1'b1, 32'h0000_0010));
    send_word(make_tick(8'd77, 1'b0, 1'b1, 32'h0000_0000));
    // host mode: hex, blank, and a value that keeps the digit
    send_word(make_cmd(1'b1, 8'd0, 8'd15, sdm_pkg::SEG_BLANK));
    send_word(make_tick(8'd33, 1'b0, 1'b1, 32'h0));
    send_word(make_cmd(1'b1, 8'd16, 8'd200, 8'd9));  // enter again: saved mode kept
    send_word(make_tick(8'd33, 1'b1, 1'b0, 32'h0));
    send_word(make_cmd(1'b0, 8'd1, 8'd2, 8'd3));
    send_word(make_cmd(1'b0, 8'd4, 8'd5, 8'd6));      // leave while not in host mode
    send_word(make_tick(8'd64, 1'b0, 1'b1, 32'h0000_0003));
    // host entered from fault mode, left again: fault scan resumes
    send_word(make_cmd(1'b1, 8'd10, 8'd11, 8'd12));
    send_word(make_tick(8'd64, 1'b0, 1'b1, 32'h0000_0003));
    send_word(make_cmd(1'b0, 8'd0, 8'd0, 8'd0));
    send_word(make_tick(8'd64, 1'b0, 1'b1, 32'h0000_0003));
    send_word(make_tick(8'd64, 1'b0, 1'b1, 32'h0000_0003));
    repeat (3) send_word(make_tick(8'd1, 1'b1, 1'b0, 32'h0));

    // random: fault set held across ticks so scans run to completion
    fault_now = fresh_faults();
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      no_gaps = (i >= 200 && i < 300);
      r = $urandom_range(99);
      if (r < 9) begin
        send_word(make_cmd(1'($urandom_range(1)), host_byte(), host_byte(), host_byte()));
      end else begin
        if ($urandom_range(99) < 15) fault_now = fresh_faults();
        r = $urandom_range(9);
        if (r < 6) lvl = 8'($urandom_range(100));
        else if (r < 8) lvl = 8'($urandom_range(255, 101));
        else lvl = 8'(level_marks[$urandom_range(16)]);
        send_word(make_tick(lvl, 1'($urandom_range(1)), $urandom_range(9) < 7, fault_now));
      end
    end
    no_gaps = 1'b0;
    s_axis_tvalid <= 1'b0;

    // drain, then allow the input and result registers to show any stray word
    while (chk.frames_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (chk.errors == 0 && chk.frames_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
